@@ hw/rtl/mer_pkg.sv @@
// Shared types and constants for the midpoint ellipse rasterizer.
package mer_pkg;

   // default coordinate width; radii are one bit narrower, outputs two bits wider
   localparam int COORD_BITS_DEF = 12;

   // internal decision and slope terms wrap modulo 2^64
   localparam int DATA_BITS = 64;

   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_RADIUS_X = 2'd2,
      CSR_RADIUS_Y = 2'd3
   } csr_index_type;

   // sequencer to output stage: load a point set
   typedef struct packed {
      logic push;
      logic last;
   } emit_ctl_type;

endpackage

@@ hw/rtl/midpoint_ellipse_rasterizer.sv @@
// Top level of the two-region midpoint ellipse rasterizer.
//
// Configure center and radii through the csr_ port (index 0..3: center x,
// center y, radius x, radius y), then send a request with req_restart = 1 to
// start an ellipse and requests with req_restart = 0 to advance it. Every
// step returns one set of four mirrored points (right/left x, lower/upper y);
// the final set carries rsp_last, and advance requests after it return
// nothing. An advance step, once accepted, adds on the offsets and slope
// terms and then on the decision term before its set is loaded into the
// output register. The first advance after region one ends also rebuilds the
// region-two decision value from five products on one shared registered
// multiplier. A restart first builds the initial terms. Writing either radius
// makes the next request first recompute the squares of the radii on the
// same multiplier. An advance request on a finished ellipse is accepted with
// no response. A new request is accepted while the previous response is
// still waiting in the output register; csr writes are always accepted and
// belong between ellipses or between steps.
module midpoint_ellipse_rasterizer
   import mer_pkg::*;
   #(
   parameter int COORD_BITS = COORD_BITS_DEF
   )
   (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_restart,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [COORD_BITS+1:0]   rsp_right_x,
   output logic signed [COORD_BITS+1:0]   rsp_left_x,
   output logic signed [COORD_BITS+1:0]   rsp_lower_y,
   output logic signed [COORD_BITS+1:0]   rsp_upper_y,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [COORD_BITS-1:0]          csr_data
   );

   localparam int C = COORD_BITS;
   localparam int W = COORD_BITS + 2;

   // configuration registers
   logic [C-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [C-2:0] rx_ff, rx_in, ry_ff, ry_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] right_ff, right_in, left_ff, left_in;
   logic [W-1:0] lower_ff, lower_in, upper_ff, upper_in;
   logic         last_ff, last_in;

   logic csr_wr, radius_wr, out_free, start;
   emit_ctl_type emit;
   logic [C-1:0] offset_x, offset_y;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   // squares of the radii are cached in the sequencer; flag them stale
   assign radius_wr = csr_wr && ((csr_index == CSR_RADIUS_X) || (csr_index == CSR_RADIUS_Y));

   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      rx_in = rx_ff;
      ry_in = ry_ff;
      if (csr_wr) begin
         case (csr_index)
            CSR_CENTER_X: cx_in = csr_data;
            CSR_CENTER_Y: cy_in = csr_data;
            CSR_RADIUS_X: rx_in = csr_data[C-2:0];
            CSR_RADIUS_Y: ry_in = csr_data[C-2:0];
            default: cx_in = cx_ff;
         endcase
      end
   end

   // a pending response never blocks the sequencer until it has a new one
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign start    = req_valid && req_ready;

   mer_seq #(.COORD_BITS(COORD_BITS)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .restart   (req_restart),
      .radius_wr (radius_wr),
      .radius_x  (rx_ff),
      .radius_y  (ry_ff),
      .out_free  (out_free),
      .ready     (req_ready),
      .emit      (emit),
      .offset_x  (offset_x),
      .offset_y  (offset_y)
   );

   // mirrored points, wrapped to the output width
   always_comb begin
      rsp_valid_in = emit.push || (rsp_valid_ff && !rsp_ready);
      right_in     = right_ff;
      left_in      = left_ff;
      lower_in     = lower_ff;
      upper_in     = upper_ff;
      last_in      = last_ff;
      if (emit.push) begin
         right_in = W'(cx_ff) + W'(offset_x);
         left_in  = W'(cx_ff) - W'(offset_x);
         lower_in = W'(cy_ff) + W'(offset_y);
         upper_in = W'(cy_ff) - W'(offset_y);
         last_in  = emit.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff        <= '0;
         cy_ff        <= '0;
         rx_ff        <= '0;
         ry_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         rx_ff        <= rx_in;
         ry_ff        <= ry_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      right_ff <= right_in;
      left_ff  <= left_in;
      lower_ff <= lower_in;
      upper_ff <= upper_in;
      last_ff  <= last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_right_x = $signed(right_ff);
   assign rsp_left_x  = $signed(left_ff);
   assign rsp_lower_y = $signed(lower_ff);
   assign rsp_upper_y = $signed(upper_ff);
   assign rsp_last    = last_ff;

endmodule

@@ hw/rtl/mer_mul.sv @@
// Shared registered unsigned multiplier.
module mer_mul
   #(
   parameter int A_BITS = 22,
   parameter int B_BITS = 26
   )
   (
   input  logic                       clock,
   input  logic [A_BITS-1:0]          mul_a,
   input  logic [B_BITS-1:0]          mul_b,
   output logic [A_BITS+B_BITS-1:0]   prod
   );

   logic [A_BITS+B_BITS-1:0] prod_ff;
   logic [A_BITS+B_BITS-1:0] prod_in;

   assign prod_in = {{B_BITS{1'b0}}, mul_a} * {{A_BITS{1'b0}}, mul_b};
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

@@ hw/rtl/mer_seq.sv @@
// Step sequencer: offsets, slope terms, decision value, region control.
module mer_seq
   import mer_pkg::*;
   #(
   parameter int COORD_BITS = COORD_BITS_DEF
   )
   (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    restart,
   input  logic                    radius_wr,
   input  logic [COORD_BITS-2:0]   radius_x,
   input  logic [COORD_BITS-2:0]   radius_y,
   input  logic                    out_free,
   output logic                    ready,
   output emit_ctl_type            emit,
   output logic [COORD_BITS-1:0]   offset_x,
   output logic [COORD_BITS-1:0]   offset_y
   );

   localparam int C       = COORD_BITS;
   localparam int D       = DATA_BITS;
   localparam int SQ_BITS = 2 * C - 2;
   localparam int A_BITS  = SQ_BITS;
   localparam int B_BITS  = 2 * C + 2;
   localparam int P_BITS  = A_BITS + B_BITS;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQ0, ST_SQ1, ST_SQ2,
      ST_INI0, ST_INI1, ST_INI2,
      ST_SW0, ST_SW1, ST_SW2, ST_SW3, ST_SW4, ST_SW5,
      ST_RND,
      ST_STP1, ST_STP2,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic fin_ff, fin_in;
   logic r2_ff, r2_in;
   logic stale_ff, stale_in;
   logic rst_ff, rst_in;
   logic [C-1:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [D-1:0] sx_ff, sx_in, sy_ff, sy_in, dec_ff, dec_in, t_ff, t_in;
   logic [SQ_BITS-1:0] rx2_ff, rx2_in, ry2_ff, ry2_in;

   logic [A_BITS-1:0] mul_a;
   logic [B_BITS-1:0] mul_b;
   logic [P_BITS-1:0] prod;
   logic [D-1:0] prod_d, rx2_d, ry2_d, two_rx2, two_ry2, rnd, sx_sel, sy_sel;
   logic [C:0]   tx;
   logic [C-1:0] ym;
   logic r1_go, more, dec_neg, dec_pos, go_rst, use_sx, use_sy;
   state_type work_state;

   mer_mul #(.A_BITS(A_BITS), .B_BITS(B_BITS)) u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   assign prod_d  = D'(prod);
   assign rx2_d   = D'(rx2_ff);
   assign ry2_d   = D'(ry2_ff);
   assign two_rx2 = D'({rx2_ff, 1'b0});
   assign two_ry2 = D'({ry2_ff, 1'b0});

   assign r1_go   = !r2_ff && (sx_ff < sy_ff);
   assign more    = r1_go || (oy_ff != '0);
   assign dec_neg = dec_ff[D-1];
   assign dec_pos = !dec_neg && (dec_ff != '0);

   assign tx = {ox_ff, 1'b1};
   // (y-1)^2 with y = 0 squares minus one
   assign ym = (oy_ff == '0) ? C'(1) : oy_ff - C'(1);

   // (t)/4 truncated toward zero
   assign rnd = {{2{t_ff[D-1]}}, t_ff[D-1:2]} + D'(t_ff[D-1] && (t_ff[1:0] != 2'b00));

   assign use_sx = r2_ff ? !dec_pos : 1'b1;
   assign use_sy = r2_ff ? 1'b1 : !dec_neg;
   assign sx_sel = use_sx ? sx_ff : '0;
   assign sy_sel = use_sy ? sy_ff : '0;

   assign go_rst     = (state_ff == ST_IDLE) ? restart : rst_ff;
   assign work_state = go_rst ? ST_INI0 : ((r2_ff || r1_go) ? ST_STP1 : ST_SW0);

   assign ready    = (state_ff == ST_IDLE);
   assign offset_x = ox_ff;
   assign offset_y = oy_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQ0: begin
            mul_a = A_BITS'(radius_x);
            mul_b = B_BITS'(radius_x);
         end
         ST_SQ1: begin
            mul_a = A_BITS'(radius_y);
            mul_b = B_BITS'(radius_y);
         end
         ST_INI0: begin
            mul_a = rx2_ff;
            mul_b = B_BITS'(radius_y);
         end
         ST_SW0: begin
            mul_a = A_BITS'(tx);
            mul_b = B_BITS'(tx);
         end
         ST_SW1: begin
            mul_a = ry2_ff;
            mul_b = prod[B_BITS-1:0];
         end
         ST_SW2: begin
            mul_a = A_BITS'(ym);
            mul_b = B_BITS'(ym);
         end
         ST_SW3: begin
            mul_a = rx2_ff;
            mul_b = prod[B_BITS-1:0];
         end
         ST_SW4: begin
            mul_a = rx2_ff;
            mul_b = B_BITS'(ry2_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      fin_in    = fin_ff;
      r2_in     = r2_ff;
      stale_in  = stale_ff || radius_wr;
      rst_in    = start ? restart : rst_ff;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      dec_in    = dec_ff;
      t_in      = t_ff;
      rx2_in    = rx2_ff;
      ry2_in    = ry2_ff;
      emit.push = 1'b0;
      emit.last = !more;
      case (state_ff)
         ST_IDLE: begin
            if (start && (restart || !fin_ff)) begin
               state_in = stale_ff ? ST_SQ0 : work_state;
            end
         end
         ST_SQ0: state_in = ST_SQ1;
         ST_SQ1: begin
            rx2_in   = prod[SQ_BITS-1:0];
            state_in = ST_SQ2;
         end
         ST_SQ2: begin
            ry2_in   = prod[SQ_BITS-1:0];
            stale_in = 1'b0;
            state_in = work_state;
         end
         ST_INI0: state_in = ST_INI1;
         ST_INI1: begin
            ox_in    = '0;
            oy_in    = {1'b0, radius_y};
            sx_in    = '0;
            sy_in    = {prod_d[D-2:0], 1'b0};
            r2_in    = 1'b0;
            t_in     = D'({ry2_ff, 2'b00}) + rx2_d + D'(2);
            state_in = ST_INI2;
         end
         ST_INI2: begin
            t_in     = t_ff - {sy_ff[D-2:0], 1'b0};
            state_in = ST_RND;
         end
         ST_SW0: state_in = ST_SW1;
         ST_SW1: state_in = ST_SW2;
         ST_SW2: begin
            t_in     = prod_d + D'(2);
            state_in = ST_SW3;
         end
         ST_SW3: state_in = ST_SW4;
         ST_SW4: begin
            t_in     = t_ff + {prod_d[D-3:0], 2'b00};
            state_in = ST_SW5;
         end
         ST_SW5: begin
            t_in     = t_ff - {prod_d[D-3:0], 2'b00};
            state_in = ST_RND;
         end
         ST_RND: begin
            dec_in = rnd;
            if (rst_ff) begin
               state_in = ST_EMIT;
            end else begin
               r2_in    = 1'b1;
               state_in = ST_STP1;
            end
         end
         ST_STP1: begin
            if (r2_ff) begin
               if (oy_ff == '0) begin
                  fin_in   = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  oy_in = oy_ff - C'(1);
                  sy_in = sy_ff - two_rx2;
                  if (!dec_pos) begin
                     ox_in = ox_ff + C'(1);
                     sx_in = sx_ff + two_ry2;
                  end
                  t_in     = dec_ff + rx2_d;
                  state_in = ST_STP2;
               end
            end else begin
               ox_in = ox_ff + C'(1);
               sx_in = sx_ff + two_ry2;
               if (!dec_neg) begin
                  oy_in = oy_ff - C'(1);
                  sy_in = sy_ff - two_rx2;
               end
               t_in     = dec_ff + ry2_d;
               state_in = ST_STP2;
            end
         end
         ST_STP2: begin
            // offsets and slopes are final here, only the decision moves
            dec_in = t_ff + sx_sel - sy_sel;
            if (out_free) begin
               emit.push = 1'b1;
               fin_in    = !more;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               emit.push = 1'b1;
               fin_in    = !more;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fin_ff   <= 1'b1;
         r2_ff    <= 1'b0;
         stale_ff <= 1'b1;
         rst_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
         r2_ff    <= r2_in;
         stale_ff <= stale_in;
         rst_ff   <= rst_in;
      end
      ox_ff  <= ox_in;
      oy_ff  <= oy_in;
      sx_ff  <= sx_in;
      sy_ff  <= sy_in;
      dec_ff <= dec_in;
      t_ff   <= t_in;
      rx2_ff <= rx2_in;
      ry2_ff <= ry2_in;
   end

endmodule

@@ hw/rtl/mer_checker.sv @@
// Port-level checker for the midpoint ellipse rasterizer, with its bind.
module mer_port_checker
   import mer_pkg::*;
   #(
   parameter int COORD_BITS = COORD_BITS_DEF
   )
   (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_restart,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic signed [COORD_BITS+1:0]   rsp_right_x,
   input logic signed [COORD_BITS+1:0]   rsp_left_x,
   input logic signed [COORD_BITS+1:0]   rsp_lower_y,
   input logic signed [COORD_BITS+1:0]   rsp_upper_y,
   input logic                           rsp_last,
   input logic                           csr_valid,
   input logic                           csr_ready
   );

   // a restart always takes the sequencer out of idle
   a_restart_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_restart |=> !req_ready)
      else $error("request ready right after a restart");

   // a new response is only loaded by a busy sequencer
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response appeared while the sequencer was idle");

   // the final set sits on the horizontal axis
   a_last_on_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_lower_y == rsp_upper_y)
      else $error("final point set has a nonzero y offset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_right_x) && $stable(rsp_left_x)
         && $stable(rsp_lower_y) && $stable(rsp_upper_y) && $stable(rsp_last))
      else $error("stalled response changed");

   // register writes never wait
   a_csr_taken: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write held off");

endmodule

bind midpoint_ellipse_rasterizer mer_port_checker #(.COORD_BITS(COORD_BITS)) u_mer_port_checker (.*);

@@ test/mer_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the midpoint ellipse rasterizer: tracks the walk and checks every point set.
module mer_checker
   import mer_pkg::*;
   #(
   parameter int COORD_BITS = COORD_BITS_DEF
   )
   (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_restart,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [COORD_BITS+1:0]       rsp_right_x,
   input  logic [COORD_BITS+1:0]       rsp_left_x,
   input  logic [COORD_BITS+1:0]       rsp_lower_y,
   input  logic [COORD_BITS+1:0]       rsp_upper_y,
   input  logic                        rsp_last,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [COORD_BITS-1:0]       csr_data,
   output int                          fail_count,
   output int                          pending,
   output int                          sets_predicted
   );

   localparam int OUT_BITS = COORD_BITS + 2;

   typedef logic [DATA_BITS-1:0] word_type;

   localparam word_type COORD_MASK = {{(DATA_BITS-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};

   typedef struct packed {
      logic [OUT_BITS-1:0] right_x;
      logic [OUT_BITS-1:0] left_x;
      logic [OUT_BITS-1:0] lower_y;
      logic [OUT_BITS-1:0] upper_y;
      logic                last;
   } point_set_type;

   point_set_type sets_due[$];

   // configuration copy
   word_type ctr_x, ctr_y, rad_x, rad_y;
   // walk state
   word_type off_x, off_y, slope_x, slope_y, decision;
   logic     region_two, done;

   // quarter-unit value to integer, quotient truncated toward zero
   function automatic word_type round_quarter(word_type a4);
      longint q;
      q = $signed(a4 + 64'd2) / 64'sd4;
      return word_type'(q);
   endfunction

   task automatic emit_set();
      point_set_type ps;
      word_type      t;
      logic          more;
      more = (!region_two && slope_x < slope_y) || off_y != 0;
      t = ctr_x + off_x;
      ps.right_x = t[OUT_BITS-1:0];
      t = ctr_x - off_x;
      ps.left_x = t[OUT_BITS-1:0];
      t = ctr_y + off_y;
      ps.lower_y = t[OUT_BITS-1:0];
      t = ctr_y - off_y;
      ps.upper_y = t[OUT_BITS-1:0];
      ps.last = !more;
      done = !more;
      sets_due.push_back(ps);
      sets_predicted++;
   endtask

   task automatic step_ellipse(input logic restart_bit);
      word_type rx2, ry2, tx, ym;
      rx2 = rad_x * rad_x;
      ry2 = rad_y * rad_y;
      if (restart_bit) begin
         off_x = '0;
         off_y = rad_y;
         slope_x = '0;
         slope_y = 2 * rx2 * rad_y;
         decision = round_quarter(4 * ry2 - 4 * rx2 * rad_y + rx2);
         region_two = 1'b0;
         emit_set();
      end else if (!done) begin
         if (!region_two && slope_x < slope_y) begin
            // region one: x always moves
            off_x = (off_x + 1) & COORD_MASK;
            slope_x = slope_x + 2 * ry2;
            if (decision[DATA_BITS-1]) begin
               decision = decision + ry2 + slope_x;
            end else begin
               off_y = (off_y - 1) & COORD_MASK;
               slope_y = slope_y - 2 * rx2;
               decision = decision + ry2 + slope_x - slope_y;
            end
            emit_set();
         end else begin
            if (!region_two) begin
               // first step past region one rebuilds the decision term
               tx = 2 * off_x + 1;
               ym = off_y - 1;
               decision = round_quarter(ry2 * tx * tx + 4 * rx2 * ym * ym - 4 * rx2 * ry2);
               region_two = 1'b1;
            end
            if (off_y == 0) begin
               done = 1'b1;
            end else begin
               // region two: y always moves
               off_y = (off_y - 1) & COORD_MASK;
               slope_y = slope_y - 2 * rx2;
               if (!decision[DATA_BITS-1] && decision != 0) begin
                  decision = decision + rx2 - slope_y;
               end else begin
                  off_x = (off_x + 1) & COORD_MASK;
                  slope_x = slope_x + 2 * ry2;
                  decision = decision + rx2 - slope_y + slope_x;
               end
               emit_set();
            end
         end
      end
   endtask

   task automatic compare_field(input string name, input logic [OUT_BITS-1:0] want,
                                input logic [OUT_BITS-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, $signed(want), $signed(got));
         fail_count++;
      end
   endtask

   task automatic check_set();
      point_set_type want;
      if (sets_due.size() == 0) begin
         $error("point set with no request waiting: right_x %0d lower_y %0d",
                $signed(rsp_right_x), $signed(rsp_lower_y));
         fail_count++;
      end else begin
         want = sets_due.pop_front();
         compare_field("right_x", want.right_x, rsp_right_x);
         compare_field("left_x", want.left_x, rsp_left_x);
         compare_field("lower_y", want.lower_y, rsp_lower_y);
         compare_field("upper_y", want.upper_y, rsp_upper_y);
         compare_field("last", {{(OUT_BITS-1){1'b0}}, want.last},
                       {{(OUT_BITS-1){1'b0}}, rsp_last});
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         ctr_x = '0;
         ctr_y = '0;
         rad_x = '0;
         rad_y = '0;
         off_x = '0;
         off_y = '0;
         slope_x = '0;
         slope_y = '0;
         decision = '0;
         region_two = 1'b0;
         done = 1'b1;
         sets_due.delete();
         fail_count = 0;
         sets_predicted = 0;
      end else begin
         // retire before predicting so a same-edge request cannot be matched early
         if (rsp_valid && rsp_ready) check_set();
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CENTER_X: ctr_x = word_type'(csr_data);
               CSR_CENTER_Y: ctr_y = word_type'(csr_data);
               CSR_RADIUS_X: rad_x = word_type'(csr_data[COORD_BITS-2:0]);
               CSR_RADIUS_Y: rad_y = word_type'(csr_data[COORD_BITS-2:0]);
               default: ;
            endcase
         end
         if (req_valid && req_ready) step_ellipse(req_restart);
      end
      pending = sets_due.size();
   end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the midpoint ellipse rasterizer: stimulus, flow control and verdict.
module tb_top;
   import mer_pkg::*;

   localparam int COORD_BITS = COORD_BITS_DEF;
   localparam int SET_TARGET = 600;          // point sets before random stimulus stops
   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 24;        // covers restart, region switch and radius reload
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int SMALL_RADIUS_MAX = 24;

   localparam logic [COORD_BITS-1:0] CENTER_MAX = '1;
   localparam logic [COORD_BITS-1:0] RADIUS_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

   // receiver back-pressure styles
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_SPARSE,
      STALL_PERIODIC
   } stall_mode_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic                         req_restart = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [COORD_BITS+1:0] rsp_right_x;
   logic signed [COORD_BITS+1:0] rsp_left_x;
   logic signed [COORD_BITS+1:0] rsp_lower_y;
   logic signed [COORD_BITS+1:0] rsp_upper_y;
   logic                         rsp_last;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_INDEX_BITS-1:0]    csr_index = CSR_CENTER_X;
   logic [COORD_BITS-1:0]        csr_data = '0;

   int fail_count;
   int pending;
   int sets_predicted;

   int cycle_count = 0;
   int burst_left = 0;
   int hold_token = 0;

   // last value written to each register, indexed by register
   logic [COORD_BITS-1:0] next_cfg [4];

   always #5 clock = ~clock;

   midpoint_ellipse_rasterizer #(
      .COORD_BITS (COORD_BITS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_restart (req_restart),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_right_x (rsp_right_x),
      .rsp_left_x  (rsp_left_x),
      .rsp_lower_y (rsp_lower_y),
      .rsp_upper_y (rsp_upper_y),
      .rsp_last    (rsp_last),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   mer_checker #(
      .COORD_BITS (COORD_BITS)
   ) scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_right_x    (rsp_right_x),
      .rsp_left_x     (rsp_left_x),
      .rsp_lower_y    (rsp_lower_y),
      .rsp_upper_y    (rsp_upper_y),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .fail_count     (fail_count),
      .pending        (pending),
      .sets_predicted (sets_predicted)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver. A change of hold_token starts one long hold-off; otherwise the
   // stall style is redrawn each time its random run length runs out, STALL_NONE
   // included so that some stretches run at full rate.
   int             hold_seen = 0;
   int             hold_left = 0;
   int             mode_left = 0;
   int             pattern_step = 0;
   stall_mode_type stall_mode = STALL_NONE;

   always @(posedge clock) begin
      if (hold_seen != hold_token) begin
         hold_seen = hold_token;
         hold_left = LONG_HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         pattern_step++;
         case (stall_mode)
            STALL_NONE:     rsp_ready <= 1'b1;
            STALL_RANDOM:   rsp_ready <= 1'($urandom_range(0, 1));
            STALL_SPARSE:   rsp_ready <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: rsp_ready <= (pattern_step % 7) < 4;
            default:        rsp_ready <= 1'b1;
         endcase
      end
   end

   // One request. Valid stays up into the next request while a burst lasts;
   // when the burst ends it drops for a random gap and a new burst is drawn.
   task automatic send_request(input logic restart_bit);
      req_valid <= 1'b1;
      req_restart <= restart_bit;
      do @(posedge clock); while (!req_ready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 5);
      end
   endtask

   task automatic send_advances(input int count);
      repeat (count) send_request(1'b0);
   endtask

   // Drain: every expected point set back, then room for a request that
   // produces nothing to finish before the registers change.
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input logic [3:0] which);
      for (int i = 0; i < 4; i++) begin
         if (which[i]) begin
            csr_valid <= 1'b1;
            csr_index <= csr_index_type'(i);
            csr_data <= next_cfg[i];
            do @(posedge clock); while (!csr_ready);
         end
      end
      csr_valid <= 1'b0;
   endtask

   task automatic load_config(input logic [COORD_BITS-1:0] cx, input logic [COORD_BITS-1:0] cy,
                              input logic [COORD_BITS-1:0] rx, input logic [COORD_BITS-1:0] ry);
      next_cfg[CSR_CENTER_X] = cx;
      next_cfg[CSR_CENTER_Y] = cy;
      next_cfg[CSR_RADIUS_X] = rx;
      next_cfg[CSR_RADIUS_Y] = ry;
      write_regs(4'hf);
   endtask

   function automatic logic [COORD_BITS-1:0] pick_center();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return CENTER_MAX;
         default: return COORD_BITS'($urandom_range(0, CENTER_MAX));
      endcase
   endfunction

   function automatic logic [COORD_BITS-1:0] pick_radius(input logic wide);
      if (!wide) return COORD_BITS'($urandom_range(0, SMALL_RADIUS_MAX));
      case ($urandom_range(0, 3))
         0:       return RADIUS_MAX;
         1:       return '0;
         2:       return COORD_BITS'(1);
         default: return COORD_BITS'($urandom_range(0, RADIUS_MAX));
      endcase
   endfunction

   // Rewrite a random subset of registers. For small ellipses a radius still
   // holding a wide value is always rewritten so the walk stays short.
   task automatic reconfigure(input logic wide);
      logic [3:0] which;
      which = 4'($urandom_range(1, 15));
      if (!wide && next_cfg[CSR_RADIUS_X] > SMALL_RADIUS_MAX) which[CSR_RADIUS_X] = 1'b1;
      if (!wide && next_cfg[CSR_RADIUS_Y] > SMALL_RADIUS_MAX) which[CSR_RADIUS_Y] = 1'b1;
      if (which[CSR_CENTER_X]) next_cfg[CSR_CENTER_X] = pick_center();
      if (which[CSR_CENTER_Y]) next_cfg[CSR_CENTER_Y] = pick_center();
      if (which[CSR_RADIUS_X]) next_cfg[CSR_RADIUS_X] = pick_radius(wide);
      if (which[CSR_RADIUS_Y]) next_cfg[CSR_RADIUS_Y] = pick_radius(wide);
      write_regs(which);
   endtask

   // Long receiver hold while requests keep coming back to back.
   task automatic start_long_hold();
      hold_token <= hold_token + 1;
      burst_left = 12;
   endtask

   initial begin
      int full_steps;
      int extra;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // ---- directed ----
      // advance out of reset: nothing happens
      send_request(1'b0);
      wait_idle();

      // all radii zero: one final set at the centre, then an ignored advance
      load_config('0, '0, '0, '0);
      send_request(1'b1);
      send_request(1'b0);
      wait_idle();

      // widest x, zero y, centre at the top corner
      load_config(CENTER_MAX, CENTER_MAX, RADIUS_MAX, '0);
      send_request(1'b1);
      wait_idle();

      // zero x radius: region one skipped, y walks down to the final set,
      // then two ignored advances
      load_config('0, '0, '0, COORD_BITS'(3));
      send_request(1'b1);
      send_advances(5);
      wait_idle();

      // tall and thin at the origin: negative left and upper coordinates,
      // early region switch with large products
      load_config('0, '0, COORD_BITS'(1), RADIUS_MAX);
      send_request(1'b1);
      send_advances(3);
      wait_idle();

      // widest ellipse at the far corner with the receiver held off, then a
      // restart in the middle of the walk
      load_config(CENTER_MAX, CENTER_MAX, RADIUS_MAX, RADIUS_MAX);
      start_long_hold();
      send_request(1'b1);
      send_advances(8);
      send_request(1'b1);
      send_advances(2);
      wait_idle();

      // ---- random ----
      while (sets_predicted < SET_TARGET) begin
         if ($urandom_range(0, 7) == 0) start_long_hold();
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               // complete small ellipse, sometimes with idle advances after it
               reconfigure(1'b0);
               full_steps = next_cfg[CSR_RADIUS_X] + next_cfg[CSR_RADIUS_Y] + 3;
               extra = $urandom_range(0, 3);
               send_request(1'b1);
               send_advances(full_steps + extra);
            end
            6: begin
               // restart part way through, then finish the new one
               reconfigure(1'b0);
               send_request(1'b1);
               send_advances($urandom_range(1, 8));
               send_request(1'b1);
               send_advances(next_cfg[CSR_RADIUS_X] + next_cfg[CSR_RADIUS_Y] + 3);
            end
            7: begin
               // registers change between steps of a running ellipse
               reconfigure(1'b0);
               send_advances($urandom_range(1, 12));
            end
            8: begin
               // wide radii: only the opening steps
               reconfigure(1'b1);
               send_request(1'b1);
               send_advances($urandom_range(1, 12));
            end
            default: begin
               // noise: random mix of restarts and advances
               repeat ($urandom_range(3, 10)) send_request($urandom_range(0, 3) == 0);
            end
         endcase
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ midpoint_ellipse_rasterizer.f @@
hw/rtl/mer_pkg.sv
hw/rtl/mer_mul.sv
hw/rtl/mer_seq.sv
hw/rtl/midpoint_ellipse_rasterizer.sv
hw/rtl/mer_checker.sv
test/mer_checker.sv
test/tb_top.sv
